// ===== hw/rtl/sbtm_pkg.sv =====
// shared types and constants of the serial bus transaction master
// no dependencies; imported by sbtm_ctrl, sbtm_dpath and the top level
package sbtm_pkg;

	typedef enum logic [1:0] {
		ACT_ENQ  = 2'd0,
		ACT_RX   = 2'd1,
		ACT_TICK = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_TX    = 2'd0,
		KIND_REPLY = 2'd1,
		KIND_ERR   = 2'd2,
		KIND_ENQ   = 2'd3
	} kind_t;

	localparam logic [2:0] ENQ_OK       = 3'd0;
	localparam logic [2:0] ENQ_ACTIVE   = 3'd1;
	localparam logic [2:0] ENQ_QUEUED   = 3'd2;
	localparam logic [2:0] ENQ_FULL     = 3'd3;
	localparam logic [2:0] ENQ_TOO_LONG = 3'd4;
	localparam logic [2:0] ERR_TIMEOUT  = 3'd0;
	localparam logic [2:0] ERR_CHECKSUM = 3'd1;

	localparam logic [1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_GAP     = 2'd1;
	localparam logic [1:0] CFG_QLIMIT  = 2'd2;

	localparam logic [15:0] TIMEOUT_RST = 16'd100;
	localparam logic [7:0]  GAP_RST     = 8'd5;
	localparam logic [2:0]  QLIMIT_RST  = 3'd4;
	localparam logic [7:0]  CHK_SEED    = 8'hAA;

	typedef enum logic [2:0] {
		EM_ENQ = 3'd0,
		EM_TO  = 3'd1,
		EM_CK  = 3'd2,
		EM_DLV = 3'd3,
		EM_TX  = 3'd4
	} emit_sel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_ENQ_CHECK,
		S_COPY_RD,
		S_COPY_WR,
		S_ENQ_EMIT,
		S_TICK_TO,
		S_TO_EMIT,
		S_TICK_GAP,
		S_SUM_RD,
		S_SUM_ACC,
		S_DLV_RD,
		S_DLV_EMIT,
		S_CK_EMIT,
		S_TICK_RX,
		S_TX_RD,
		S_TX_EMIT
	} state_t;

	typedef struct packed {
		logic      latch_in;
		logic      stage_push;
		logic      rx_push;
		logic      check_latch;
		logic      copy_rd;
		logic      copy_wr;
		logic      commit;
		logic      staging_clr;
		logic      sent_tick;
		logic      abort;
		logic      frame_take;
		logic      deactivate;
		logic      sum_acc;
		logic      rx_rd;
		logic      idx_clr;
		logic      idx_inc;
		logic      rx_age;
		logic      tx_start;
		logic      tx_rd;
		logic      tx_done;
		logic      emit;
		emit_sel_t sel;
	} cmd_t;

	typedef struct packed {
		action_t action;
		logic    last;
		logic    reject;
		logic    copy_more;
		logic    active;
		logic    timeout_hit;
		logic    frame_ready;
		logic    frame_multi;
		logic    idx_last;
		logic    sum_ok;
		logic    queue_pending;
		logic    tx_last;
		logic    emit_ok;
	} sts_t;

	function automatic logic [7:0] fold16(input logic [15:0] t);
		return t[15:8] + t[7:0];
	endfunction

endpackage

// ===== hw/rtl/sbtm_in_if.sv =====
// request channel of the bus master: valid/ready plus one input item
// depends on nothing
interface sbtm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [2:0] client_id;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, action, client_id, data_byte, last_byte, input ready);
	modport sink (input valid, action, client_id, data_byte, last_byte, output ready);
endinterface

// ===== hw/rtl/sbtm_out_if.sv =====
// result channel of the bus master: valid/ready plus one result item
// depends on nothing
interface sbtm_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [2:0] target_client;
	logic [7:0] out_byte;
	logic       end_of_run;
	logic [2:0] status_code;

	modport source (output valid, kind, target_client, out_byte, end_of_run, status_code,
		input ready);
	modport sink (input valid, kind, target_client, out_byte, end_of_run, status_code,
		output ready);
endinterface

// ===== hw/rtl/sbtm_ram.sv =====
// generic single write port ram with registered read
// depends on nothing
module sbtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== hw/rtl/sbtm_ctrl.sv =====
// sequencer of the bus master: walks enqueue, receive and tick steps
// depends on sbtm_pkg; drives the datapath by cmd_t and reads sts_t
module sbtm_ctrl import sbtm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.sel  = EM_ENQ;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.action)
					ACT_ENQ: begin
						cmd.stage_push = 1'b1;
						state_d = sts.last ? S_ENQ_CHECK : S_IDLE;
					end
					ACT_RX: begin
						cmd.rx_push = 1'b1;
						state_d = S_IDLE;
					end
					ACT_TICK: state_d = S_TICK_TO;
					default:  state_d = S_IDLE;
				endcase
			end
			S_ENQ_CHECK: begin
				cmd.check_latch = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d = sts.reject ? S_ENQ_EMIT : S_COPY_RD;
			end
			S_COPY_RD: begin
				if (sts.copy_more) begin
					cmd.copy_rd = 1'b1;
					state_d = S_COPY_WR;
				end else begin
					// checksum byte, length and owner go in with the last write
					cmd.commit = 1'b1;
					state_d = S_ENQ_EMIT;
				end
			end
			S_COPY_WR: begin
				cmd.copy_wr = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d = S_COPY_RD;
			end
			S_ENQ_EMIT: begin
				cmd.sel = EM_ENQ;
				if (sts.emit_ok) begin
					cmd.emit = 1'b1;
					cmd.staging_clr = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_TICK_TO: begin
				if (sts.active) begin
					cmd.sent_tick = 1'b1;
					state_d = sts.timeout_hit ? S_TO_EMIT : S_TICK_GAP;
				end else begin
					state_d = S_TICK_GAP;
				end
			end
			S_TO_EMIT: begin
				cmd.sel = EM_TO;
				if (sts.emit_ok) begin
					cmd.emit = 1'b1;
					cmd.abort = 1'b1;
					state_d = S_TICK_GAP;
				end
			end
			S_TICK_GAP: begin
				if (sts.frame_ready) begin
					cmd.frame_take = 1'b1;
					cmd.idx_clr = 1'b1;
					if (!sts.active) begin
						state_d = S_TICK_RX;
					end else if (sts.frame_multi) begin
						state_d = S_SUM_RD;
					end else begin
						state_d = S_DLV_RD;
					end
				end else begin
					state_d = S_TICK_RX;
				end
			end
			S_SUM_RD: begin
				cmd.rx_rd = 1'b1;
				state_d = S_SUM_ACC;
			end
			S_SUM_ACC: begin
				if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d = sts.sum_ok ? S_DLV_RD : S_CK_EMIT;
				end else begin
					cmd.sum_acc = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d = S_SUM_RD;
				end
			end
			S_DLV_RD: begin
				cmd.rx_rd = 1'b1;
				state_d = S_DLV_EMIT;
			end
			S_DLV_EMIT: begin
				cmd.sel = EM_DLV;
				if (sts.emit_ok) begin
					cmd.emit = 1'b1;
					if (sts.idx_last) begin
						cmd.deactivate = 1'b1;
						state_d = S_TICK_RX;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = S_DLV_RD;
					end
				end
			end
			S_CK_EMIT: begin
				cmd.sel = EM_CK;
				if (sts.emit_ok) begin
					cmd.emit = 1'b1;
					cmd.deactivate = 1'b1;
					state_d = S_TICK_RX;
				end
			end
			S_TICK_RX: begin
				cmd.rx_age = 1'b1;
				if (!sts.active && sts.queue_pending) begin
					cmd.tx_start = 1'b1;
					state_d = S_TX_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_TX_RD: begin
				cmd.tx_rd = 1'b1;
				state_d = S_TX_EMIT;
			end
			S_TX_EMIT: begin
				cmd.sel = EM_TX;
				if (sts.emit_ok) begin
					cmd.emit = 1'b1;
					if (sts.tx_last) begin
						cmd.tx_done = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = S_TX_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== hw/rtl/sbtm_dpath.sv =====
// datapath of the bus master: staging, request queue, receive buffer,
// timers, settings registers and the result register
// depends on sbtm_pkg, sbtm_ram and sbtm_out_if
module sbtm_dpath import sbtm_pkg::*; #(
	parameter int QUEUE_SLOTS = 4,
	parameter int PAYLOAD_MAX = 16,
	parameter int RX_CAP      = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [1:0]  in_action,
	input  logic [2:0]  in_client,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  cmd_t        cmd,
	output sts_t        sts,
	sbtm_out_if.source  out_ch
);
	localparam int STRIDE  = PAYLOAD_MAX + 1;
	localparam int QDEPTH  = QUEUE_SLOTS * STRIDE;
	localparam int QA_W    = QDEPTH > 1 ? $clog2(QDEPTH) : 1;
	localparam int SA_W    = PAYLOAD_MAX > 1 ? $clog2(PAYLOAD_MAX) : 1;
	localparam int RA_W    = $clog2(RX_CAP);
	localparam int SLOT_W  = QUEUE_SLOTS > 1 ? $clog2(QUEUE_SLOTS) : 1;
	localparam int QC_W    = $clog2(QUEUE_SLOTS + 1);
	localparam int TW      = QC_W + 1;
	localparam int CW      = QC_W + 3;
	localparam int SC_W    = $clog2(PAYLOAD_MAX + 1);
	localparam int RC_W    = $clog2(RX_CAP + 1);
	localparam int LEN_W   = $clog2(STRIDE + 1);
	localparam int IDX_MAX = RX_CAP > STRIDE ? RX_CAP : STRIDE;
	localparam int IDX_W   = $clog2(IDX_MAX + 1);

	// settings
	logic [15:0] timeout_q;
	logic [7:0]  gap_q;
	logic [2:0]  qlimit_q;

	// latched input item
	action_t     action_q;
	logic [2:0]  client_q;
	logic [7:0]  byte_q;
	logic        last_q;

	// staging
	logic [SC_W-1:0] stg_count_q;
	logic [15:0]     stg_sum_q;
	logic            stg_ovf_q;
	logic [7:0]      stg_rdata;

	// queue
	logic [SLOT_W-1:0] head_q;
	logic [QC_W-1:0]   qcount_q;
	logic [LEN_W-1:0]  qlen_q [QUEUE_SLOTS];
	logic [2:0]        qclient_q [QUEUE_SLOTS];
	logic [7:0]        q_rdata;

	// active transaction and receive side
	logic              active_q;
	logic [2:0]        act_client_q;
	logic [16:0]       since_sent_q;
	logic [RC_W-1:0]   rx_count_q;
	logic [RC_W-1:0]   frame_cnt_q;
	logic [8:0]        since_rx_q;
	logic [7:0]        rx_rdata;

	// walk state
	logic [IDX_W-1:0]  idx_q;
	logic [15:0]       sum_q;
	logic [LEN_W-1:0]  tx_len_q;
	logic [2:0]        enq_status_q;

	// result register
	logic       o_valid_q;
	kind_t      o_kind_q;
	logic [2:0] o_client_q;
	logic [7:0] o_byte_q;
	logic       o_eor_q;
	logic [2:0] o_status_q;

	// derived values
	logic [TW-1:0]     tail_sum;
	logic [SLOT_W-1:0] tail;
	logic [QA_W-1:0]   tail_base, head_base;
	logic              queued_hit;
	logic [CW-1:0]     limit;
	logic [2:0]        enq_status;
	logic [16:0]       sent_next;
	logic              emit_ok;
	logic              q_we;
	logic [QA_W-1:0]   q_waddr;
	logic [7:0]        q_wdata;
	logic              stg_we;
	logic              rx_we;

	assign tail_sum  = TW'(head_q) + TW'(qcount_q);
	assign tail      = (tail_sum >= TW'(QUEUE_SLOTS)) ? SLOT_W'(tail_sum - TW'(QUEUE_SLOTS))
		: SLOT_W'(tail_sum);
	assign tail_base = QA_W'(tail) * QA_W'(STRIDE);
	assign head_base = QA_W'(head_q) * QA_W'(STRIDE);

	// is the requesting client among the pending slots
	always_comb begin
		logic [TW-1:0] off;
		queued_hit = 1'b0;
		for (int s = 0; s < QUEUE_SLOTS; s++) begin
			if (TW'(s) >= TW'(head_q)) begin
				off = TW'(s) - TW'(head_q);
			end else begin
				off = TW'(s) + TW'(QUEUE_SLOTS) - TW'(head_q);
			end
			if (off < TW'(qcount_q) && qclient_q[s] == client_q) begin
				queued_hit = 1'b1;
			end
		end
	end

	assign limit = (CW'(qlimit_q) < CW'(QUEUE_SLOTS)) ? CW'(qlimit_q) : CW'(QUEUE_SLOTS);

	always_comb begin
		if (active_q && act_client_q == client_q) begin
			enq_status = ENQ_ACTIVE;
		end else if (queued_hit) begin
			enq_status = ENQ_QUEUED;
		end else if (CW'(qcount_q) >= limit) begin
			enq_status = ENQ_FULL;
		end else if (stg_ovf_q) begin
			enq_status = ENQ_TOO_LONG;
		end else begin
			enq_status = ENQ_OK;
		end
	end

	assign sent_next = (since_sent_q == '1) ? since_sent_q : since_sent_q + 17'd1;
	assign emit_ok   = !o_valid_q || out_ch.ready;

	always_comb begin
		sts               = '0;
		sts.action        = action_q;
		sts.last          = last_q;
		sts.reject        = enq_status != ENQ_OK;
		sts.copy_more     = idx_q < IDX_W'(stg_count_q);
		sts.active        = active_q;
		sts.timeout_hit   = sent_next > {1'b0, timeout_q};
		sts.frame_ready   = rx_count_q != '0 && since_rx_q >= {1'b0, gap_q};
		sts.frame_multi   = rx_count_q >= RC_W'(2);
		sts.idx_last      = idx_q == IDX_W'(frame_cnt_q - RC_W'(1));
		sts.sum_ok        = fold16(sum_q) == rx_rdata;
		sts.queue_pending = qcount_q != '0;
		sts.tx_last       = idx_q == IDX_W'(tx_len_q - LEN_W'(1));
		sts.emit_ok       = emit_ok;
	end

	// memories
	assign stg_we = cmd.stage_push && stg_count_q < SC_W'(PAYLOAD_MAX);
	assign rx_we  = cmd.rx_push && rx_count_q < RC_W'(RX_CAP);

	sbtm_ram #(.WIDTH(8), .DEPTH(PAYLOAD_MAX)) u_stg_ram (
		.clk   (clk),
		.we    (stg_we),
		.waddr (SA_W'(stg_count_q)),
		.wdata (byte_q),
		.re    (cmd.copy_rd),
		.raddr (SA_W'(idx_q)),
		.rdata (stg_rdata)
	);

	assign q_we    = cmd.copy_wr || cmd.commit;
	assign q_waddr = tail_base + (cmd.copy_wr ? QA_W'(idx_q) : QA_W'(stg_count_q));
	assign q_wdata = cmd.copy_wr ? stg_rdata : fold16(stg_sum_q);

	sbtm_ram #(.WIDTH(8), .DEPTH(QDEPTH)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (cmd.tx_rd),
		.raddr (head_base + QA_W'(idx_q)),
		.rdata (q_rdata)
	);

	sbtm_ram #(.WIDTH(8), .DEPTH(RX_CAP)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (RA_W'(rx_count_q)),
		.wdata (byte_q),
		.re    (cmd.rx_rd),
		.raddr (RA_W'(idx_q)),
		.rdata (rx_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			client_q <= in_client;
			byte_q   <= in_byte;
			last_q   <= in_last;
		end
		if (cmd.commit) begin
			qlen_q[tail]    <= LEN_W'(stg_count_q) + LEN_W'(1);
			qclient_q[tail] <= client_q;
		end
		if (cmd.check_latch) begin
			enq_status_q <= enq_status;
		end
		if (cmd.frame_take) begin
			frame_cnt_q <= rx_count_q;
		end
		if (cmd.idx_clr) begin
			sum_q <= {8'h00, CHK_SEED};
		end else if (cmd.sum_acc) begin
			sum_q <= sum_q + {8'h00, rx_rdata};
		end
		if (cmd.tx_start) begin
			tx_len_q <= qlen_q[head_q];
		end
		if (cmd.idx_clr || cmd.tx_start) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.emit) begin
			o_kind_q   <= KIND_ENQ;
			o_client_q <= act_client_q;
			o_byte_q   <= 8'h00;
			o_status_q <= 3'd0;
			o_eor_q    <= qcount_q == '0;
			case (cmd.sel)
				EM_ENQ: begin
					o_client_q <= client_q;
					o_status_q <= enq_status_q;
					o_eor_q    <= 1'b1;
				end
				EM_TO: begin
					o_kind_q   <= KIND_ERR;
					o_status_q <= ERR_TIMEOUT;
				end
				EM_CK: begin
					o_kind_q   <= KIND_ERR;
					o_status_q <= ERR_CHECKSUM;
				end
				EM_DLV: begin
					o_kind_q <= KIND_REPLY;
					o_byte_q <= rx_rdata;
					o_eor_q  <= sts.idx_last && qcount_q == '0;
				end
				EM_TX: begin
					o_kind_q <= KIND_TX;
					o_byte_q <= q_rdata;
					o_eor_q  <= sts.tx_last;
				end
				default: o_kind_q <= KIND_ENQ;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= TIMEOUT_RST;
			gap_q        <= GAP_RST;
			qlimit_q     <= QLIMIT_RST;
			action_q     <= ACT_NONE;
			stg_count_q  <= '0;
			stg_sum_q    <= {8'h00, CHK_SEED};
			stg_ovf_q    <= 1'b0;
			head_q       <= '0;
			qcount_q     <= '0;
			active_q     <= 1'b0;
			act_client_q <= '0;
			since_sent_q <= '0;
			rx_count_q   <= '0;
			since_rx_q   <= '0;
			o_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIMEOUT: timeout_q <= cfg_data;
					CFG_GAP:     gap_q     <= cfg_data[7:0];
					CFG_QLIMIT:  qlimit_q  <= cfg_data[2:0];
					default:     ;
				endcase
			end
			if (cmd.latch_in) begin
				action_q <= action_t'(in_action);
			end
			if (cmd.stage_push) begin
				if (stg_we) begin
					stg_count_q <= stg_count_q + SC_W'(1);
					stg_sum_q   <= stg_sum_q + {8'h00, byte_q};
				end else begin
					stg_ovf_q <= 1'b1;
				end
			end else if (cmd.staging_clr) begin
				stg_count_q <= '0;
				stg_sum_q   <= {8'h00, CHK_SEED};
				stg_ovf_q   <= 1'b0;
			end
			if (cmd.commit) begin
				qcount_q <= qcount_q + QC_W'(1);
			end else if (cmd.tx_done) begin
				qcount_q <= qcount_q - QC_W'(1);
				head_q   <= (head_q == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : head_q + SLOT_W'(1);
			end
			if (cmd.sent_tick) begin
				since_sent_q <= sent_next;
			end else if (cmd.tx_start) begin
				since_sent_q <= '0;
			end
			if (cmd.abort || cmd.deactivate) begin
				active_q <= 1'b0;
			end else if (cmd.tx_start) begin
				active_q     <= 1'b1;
				act_client_q <= qclient_q[head_q];
			end
			if (cmd.abort || cmd.frame_take || cmd.tx_start) begin
				rx_count_q <= '0;
			end else if (rx_we) begin
				rx_count_q <= rx_count_q + RC_W'(1);
			end
			if (cmd.rx_push) begin
				since_rx_q <= '0;
			end else if (cmd.rx_age && since_rx_q != '1) begin
				since_rx_q <= since_rx_q + 9'd1;
			end
			if (cmd.emit) begin
				o_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid         = o_valid_q;
	assign out_ch.kind          = o_kind_q;
	assign out_ch.target_client = o_client_q;
	assign out_ch.out_byte      = o_byte_q;
	assign out_ch.end_of_run    = o_eor_q;
	assign out_ch.status_code   = o_status_q;
endmodule

// ===== hw/rtl/serial_bus_transaction_master.sv =====
// top level of the serial bus transaction master
// depends on sbtm_pkg, sbtm_in_if, sbtm_out_if, sbtm_ctrl and sbtm_dpath
//
// channel   dir  handshake     payload
// in_ch     in   valid/ready   action, client_id, data_byte, last_byte
// out_ch    out  valid/ready   kind, target_client, out_byte, end_of_run, status_code
// cfg       in   cfg_we        cfg_index, cfg_data
//
// one request at a time; an accepted final enqueue byte copies the payload from
// staging to the queue through the queue ram write port, and a tick walks the checked
// frame bytes, the delivered or sent bytes and any error result one ram read at a
// time, since each ram read is registered.
// reset is asynchronous and needs no clearing pass; a stalled out_ch holds the walk
// at the next result while the last finished result waits in the output register.
module serial_bus_transaction_master import sbtm_pkg::*; #(
	parameter int QUEUE_SLOTS = 4,
	parameter int PAYLOAD_MAX = 16,
	parameter int RX_CAP      = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	sbtm_in_if.sink     in_ch,
	sbtm_out_if.source  out_ch
);
	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign in_ch.ready = in_ready;

	sbtm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbtm_dpath #(
		.QUEUE_SLOTS (QUEUE_SLOTS),
		.PAYLOAD_MAX (PAYLOAD_MAX),
		.RX_CAP      (RX_CAP)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_action (in_ch.action),
		.in_client (in_ch.client_id),
		.in_byte   (in_ch.data_byte),
		.in_last   (in_ch.last_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_ch    (out_ch)
	);
endmodule
